### design/ansi_cursor_tracker_assert.svh
// Assertion macros for the ANSI cursor tracker.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ANSI_CURSOR_TRACKER_ASSERT_SVH
`define ANSI_CURSOR_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define ACT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while in reset.
`define ACT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ACT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ACT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/act_pkg.sv
// Shared constants, types and helpers of the ANSI cursor tracker.
// Used by act_front, act_queue, act_back and ansi_cursor_tracker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

	// Screen and parser sizing
	localparam int ROWS       = 25;
	localparam int COLS       = 80;
	localparam int MAX_PARAMS = 8;
	localparam int SEQ_BUF    = 64;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 7;
	localparam int ATTR_W    = 8;
	localparam int MODE_W    = 2;
	localparam int SET_ROW_W = 6;
	localparam int SET_COL_W = 7;
	localparam int VAL_W     = 10;
	localparam int PCNT_W    = $clog2(MAX_PARAMS + 1);
	localparam int PIDX_W    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int SEQ_W     = $clog2(SEQ_BUF);

	// Command queue sizing
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Tab stops every four columns
	localparam int TAB_STEP = 4;

	localparam logic [VAL_W-1:0]  VALUE_CAP   = 10'h3FF;
	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
	localparam logic [ATTR_W-1:0] ATTR_BRIGHT = 8'h08;

	// Parameter values of interest
	localparam logic [VAL_W-1:0] SGR_RESET = 10'd0;
	localparam logic [VAL_W-1:0] SGR_BOLD  = 10'd1;
	localparam logic [VAL_W-1:0] SGR_FG_LO = 10'd30;
	localparam logic [VAL_W-1:0] SGR_FG_HI = 10'd37;
	localparam logic [VAL_W-1:0] SGR_BG_LO = 10'd40;
	localparam logic [VAL_W-1:0] SGR_BG_HI = 10'd47;
	localparam logic [VAL_W-1:0] ED_ALL    = 10'd2;

	// Byte codes
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] FINAL_LO  = 8'h40;
	localparam logic [BYTE_W-1:0] FINAL_HI  = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_B   = 8'h42;
	localparam logic [BYTE_W-1:0] CH_UP_C   = 8'h43;
	localparam logic [BYTE_W-1:0] CH_UP_D   = 8'h44;
	localparam logic [BYTE_W-1:0] CH_UP_H   = 8'h48;
	localparam logic [BYTE_W-1:0] CH_UP_J   = 8'h4A;
	localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [BYTE_W-1:0] CH_LOW_M  = 8'h6D;

	// Reported parser mode codes
	localparam logic [MODE_W-1:0] PMODE_NORMAL = 2'd0;
	localparam logic [MODE_W-1:0] PMODE_ESC    = 2'd1;
	localparam logic [MODE_W-1:0] PMODE_CSI    = 2'd2;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESC    = 3'b010,
		MODE_CSI    = 3'b100
	} parse_mode_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_SETPOS,
		CMD_LF,
		CMD_CR,
		CMD_TAB,
		CMD_BS,
		CMD_PRINT,
		CMD_CUU,
		CMD_CUD,
		CMD_CUF,
		CMD_CUB,
		CMD_CUP,
		CMD_ED,
		CMD_SGR
	} cmd_kind_t;

	typedef struct packed {
		logic             dflt;
		logic [VAL_W-1:0] val;
	} param_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic [MODE_W-1:0]           mode;
		logic [ROW_W-1:0]            set_row;
		logic [COL_W-1:0]            set_col;
		logic [PCNT_W-1:0]           pcount;
		param_t [MAX_PARAMS-1:0]     params;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic                 op;
		logic [BYTE_W-1:0]    byte_in;
		logic [SET_ROW_W-1:0] set_row;
		logic [SET_COL_W-1:0] set_col;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ATTR_W-1:0] attribute;
		logic [MODE_W-1:0] parser_mode;
	} out_item_t;

	// Map the one-hot parser state to its reported code
	function automatic logic [MODE_W-1:0] mode_code(parse_mode_t m);
		logic [MODE_W-1:0] c;
		case (m)
			MODE_ESC: c = PMODE_ESC;
			MODE_CSI: c = PMODE_CSI;
			default:  c = PMODE_NORMAL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### design/ansi_cursor_tracker.sv
// ANSI cursor tracker top level: parser front end, command queue, cursor back end.
// Depends on act_pkg, act_front, act_queue, act_back and the assertion header.
//
// Usage:
//   item (op, byte_in, set_row, set_col) enters on item_valid/item_ready;
//   one result (row, col, attribute, parser_mode) leaves per request on
//   result_valid/result_ready, in request order.
//   Path: an accepted request is stored in the queue, and its result is
//   then written into the result register once the command is at the queue
//   head and the result register is free.
//   Throughput: one request per cycle while item_ready is high. An SGR final
//   byte with N parameters (at most MAX_PARAMS = 8) holds the back end while
//   the attribute is folded one parameter a cycle.
//   Reset: cursor at 0,0, attribute 0x07, parser in normal mode, queue and
//   result register empty. No clearing pass is needed.
//   Stall: the result register holds until taken; the two-entry queue then
//   fills and item_ready drops until the receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_cursor_tracker_assert.svh"

module ansi_cursor_tracker import act_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      push;
	logic      pop;
	cmd_t      cmd;
	cmd_t      head;
	q_status_t q_status;
	logic      result_in_range;

	act_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.cmd        (cmd)
	);

	act_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	act_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Flag a result that lies on the screen with a known parser mode
	assign result_in_range = (result.row <= ROW_W'(ROWS - 1))
		&& (result.col <= COL_W'(COLS - 1))
		&& (result.parser_mode <= PMODE_CSI);

	// Check queue discipline and result ranges
	`ACT_ASSERT_IMP(a_no_push_full, clk, arst_n, q_status.full, !push, "push into full queue")
	`ACT_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_status.empty, !pop, "pop from empty queue")
	`ACT_ASSERT_NXT(a_pop_gives_result, clk, arst_n, pop, result_valid, "pop left no result")
	`ACT_ASSERT_IMP(a_result_range, clk, arst_n, result_valid, result_in_range, "result out of range")

endmodule

`default_nettype wire

### design/act_front.sv
// Front end: accepts requests, runs the escape sequence parser and
// pushes one classified command per request. Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none

module act_front import act_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	input  q_status_t q_status,
	output logic      push,
	output cmd_t      cmd
);

	parse_mode_t       mode_q, mode_d;
	logic [PCNT_W-1:0] pcount_q, pcount_d;
	logic [VAL_W-1:0]  accum_q, accum_d;
	logic              digit_q, digit_d;
	logic              bad_q, bad_d;
	logic [SEQ_W-1:0]  seq_q, seq_d;
	logic [VAL_W-1:0]  vals_q [MAX_PARAMS];

	logic              val_we;
	logic [PIDX_W-1:0] val_widx;
	logic              pend;
	logic              is_digit;
	logic              is_final;
	logic [VAL_W+3:0]  prod;
	param_t [MAX_PARAMS-1:0] fin_params;
	logic [PCNT_W-1:0] fin_n;

	// Take a request whenever the queue has room
	assign item_ready = !q_status.full;
	assign push       = item_valid && item_ready;
	assign val_widx   = pcount_q[PIDX_W-1:0];

	// Build the parameter list as a final byte would see it
	always_comb begin
		pend = !bad_q && digit_q && (pcount_q < PCNT_W'(MAX_PARAMS));
		for (int i = 0; i < MAX_PARAMS; i++) begin
			if (PCNT_W'(i) < pcount_q) begin
				fin_params[i] = '{dflt: 1'b0, val: vals_q[i]};
			end else if (pend && (PCNT_W'(i) == pcount_q)) begin
				fin_params[i] = '{dflt: 1'b0, val: accum_q};
			end else begin
				fin_params[i] = '{dflt: 1'b1, val: '0};
			end
		end
		fin_n = bad_q ? PCNT_W'(MAX_PARAMS) : pcount_q + PCNT_W'(pend);
	end

	// Classify the byte and advance the parser
	always_comb begin
		is_digit = (item.byte_in >= CH_ZERO) && (item.byte_in <= CH_NINE);
		is_final = (item.byte_in >= FINAL_LO) && (item.byte_in <= FINAL_HI);
		prod     = (VAL_W+4)'(accum_q) * (VAL_W+4)'(10)
			+ (VAL_W+4)'(item.byte_in - CH_ZERO);

		mode_d   = mode_q;
		pcount_d = pcount_q;
		accum_d  = accum_q;
		digit_d  = digit_q;
		bad_d    = bad_q;
		seq_d    = seq_q;
		val_we   = 1'b0;
		cmd.kind = CMD_NOP;

		if (item.op) begin
			cmd.kind = CMD_SETPOS;
		end else if (item.byte_in != CH_NUL) begin
			case (mode_q)
				MODE_ESC: begin
					if (item.byte_in == CH_LBRACK) begin
						mode_d   = MODE_CSI;
						pcount_d = '0;
						accum_d  = '0;
						digit_d  = 1'b0;
						bad_d    = 1'b0;
						seq_d    = '0;
					end else begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_CSI: begin
					if (is_final) begin
						case (item.byte_in)
							CH_UP_A:           cmd.kind = CMD_CUU;
							CH_UP_B:           cmd.kind = CMD_CUD;
							CH_UP_C:           cmd.kind = CMD_CUF;
							CH_UP_D:           cmd.kind = CMD_CUB;
							CH_UP_H, CH_LOW_F: cmd.kind = CMD_CUP;
							CH_UP_J:           cmd.kind = CMD_ED;
							CH_LOW_M:          cmd.kind = CMD_SGR;
							default:           cmd.kind = CMD_NOP;
						endcase
						mode_d   = MODE_NORMAL;
						pcount_d = '0;
						accum_d  = '0;
						digit_d  = 1'b0;
						bad_d    = 1'b0;
						seq_d    = '0;
					end else if (seq_q < SEQ_W'(SEQ_BUF - 1)) begin
						seq_d = seq_q + SEQ_W'(1);
						// Fold the byte into the parameter list
						if (!bad_q && (pcount_q < PCNT_W'(MAX_PARAMS))) begin
							if (is_digit) begin
								accum_d = (prod > (VAL_W+4)'(VALUE_CAP)) ?
									VALUE_CAP : prod[VAL_W-1:0];
								digit_d = 1'b1;
							end else begin
								if (digit_q) begin
									val_we   = 1'b1;
									pcount_d = pcount_q + PCNT_W'(1);
									accum_d  = '0;
									digit_d  = 1'b0;
								end
								if (item.byte_in != CH_SEMI) begin
									bad_d = 1'b1;
								end
							end
						end
					end else begin
						// Drop an overlong sequence
						mode_d   = MODE_NORMAL;
						pcount_d = '0;
						accum_d  = '0;
						digit_d  = 1'b0;
						bad_d    = 1'b0;
						seq_d    = '0;
					end
				end
				default: begin
					case (item.byte_in)
						CH_ESC: begin
							mode_d   = MODE_ESC;
							pcount_d = '0;
							accum_d  = '0;
							digit_d  = 1'b0;
							bad_d    = 1'b0;
							seq_d    = '0;
						end
						CH_LF:   cmd.kind = CMD_LF;
						CH_CR:   cmd.kind = CMD_CR;
						CH_TAB:  cmd.kind = CMD_TAB;
						CH_BS:   cmd.kind = CMD_BS;
						default: cmd.kind = CMD_PRINT;
					endcase
				end
			endcase
		end

		cmd.mode    = mode_code(mode_d);
		cmd.set_row = (item.set_row > SET_ROW_W'(ROWS - 1)) ?
			ROW_W'(ROWS - 1) : item.set_row[ROW_W-1:0];
		cmd.set_col = (item.set_col > SET_COL_W'(COLS - 1)) ?
			COL_W'(COLS - 1) : item.set_col[COL_W-1:0];
		cmd.pcount  = fin_n;
		cmd.params  = fin_params;
	end

	// Parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			pcount_q <= '0;
			accum_q  <= '0;
			digit_q  <= 1'b0;
			bad_q    <= 1'b0;
			seq_q    <= '0;
		end else if (push) begin
			mode_q   <= mode_d;
			pcount_q <= pcount_d;
			accum_q  <= accum_d;
			digit_q  <= digit_d;
			bad_q    <= bad_d;
			seq_q    <= seq_d;
		end
	end

	// Store a closed parameter
	always_ff @(posedge clk) begin
		if (push && val_we) begin
			vals_q[val_widx] <= accum_q;
		end
	end

endmodule

`default_nettype wire

### design/act_queue.sv
// Short command queue between the parser front end and the cursor back end.
// Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none

module act_queue import act_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_status
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head           = entry_q[rd_ptr_q];
	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### design/act_back.sv
// Back end: carries out queued commands on the cursor and attribute and
// holds the result register. Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none

module act_back import act_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic [ROW_W-1:0]  row_q, nrow;
	logic [COL_W-1:0]  col_q, ncol;
	logic [ATTR_W-1:0] attr_q, nattr;
	logic [PIDX_W-1:0] idx_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              head_valid;
	logic              out_free;
	logic              step_last;
	logic              advance;
	logic [ROW_W-1:0]  row_inc;
	logic [COL_W:0]    tab_c;
	logic [VAL_W-1:0]  cnt0, cnt1, a0, a1;
	logic [VAL_W:0]    sum_r, sum_c;
	param_t            sel;
	logic [VAL_W-1:0]  pv, sub30, sub40;

	assign head_valid   = !q_status.empty;
	assign out_free     = !out_valid_q || result_ready;
	assign advance      = head_valid && (!step_last || out_free);
	assign pop          = head_valid && step_last && out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Work out the next cursor and attribute for the head command
	always_comb begin
		cnt0 = (!head.params[0].dflt && (head.params[0].val != '0)) ?
			head.params[0].val : VAL_W'(1);
		cnt1 = (!head.params[1].dflt && (head.params[1].val != '0)) ?
			head.params[1].val : VAL_W'(1);
		a0      = cnt0 - VAL_W'(1);
		a1      = cnt1 - VAL_W'(1);
		sum_r   = (VAL_W+1)'(cnt0) + (VAL_W+1)'(row_q);
		sum_c   = (VAL_W+1)'(cnt0) + (VAL_W+1)'(col_q);
		row_inc = (row_q < ROW_W'(ROWS - 1)) ? row_q + ROW_W'(1) : row_q;
		tab_c   = {1'b0, col_q & ~COL_W'(TAB_STEP - 1)} + (COL_W+1)'(TAB_STEP);
		sel     = head.params[idx_q];
		pv      = sel.dflt ? '0 : sel.val;
		sub30   = pv - SGR_FG_LO;
		sub40   = pv - SGR_BG_LO;

		nrow      = row_q;
		ncol      = col_q;
		nattr     = attr_q;
		step_last = 1'b1;

		case (head.kind)
			CMD_SETPOS: begin
				nrow = head.set_row;
				ncol = head.set_col;
			end
			CMD_LF: begin
				ncol = '0;
				nrow = row_inc;
			end
			CMD_CR: begin
				ncol = '0;
			end
			CMD_TAB: begin
				if (tab_c >= (COL_W+1)'(COLS)) begin
					ncol = COL_W'(tab_c - (COL_W+1)'(COLS));
					nrow = row_inc;
				end else begin
					ncol = tab_c[COL_W-1:0];
				end
			end
			CMD_BS: begin
				if (col_q != '0) begin
					ncol = col_q - COL_W'(1);
				end else if (row_q != '0) begin
					nrow = row_q - ROW_W'(1);
					ncol = COL_W'(COLS - 1);
				end
			end
			CMD_PRINT: begin
				if (col_q >= COL_W'(COLS - 1)) begin
					ncol = '0;
					nrow = row_inc;
				end else begin
					ncol = col_q + COL_W'(1);
				end
			end
			CMD_CUU: begin
				nrow = (cnt0 > VAL_W'(row_q)) ? '0 : ROW_W'(VAL_W'(row_q) - cnt0);
			end
			CMD_CUD: begin
				nrow = (sum_r > (VAL_W+1)'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(sum_r);
			end
			CMD_CUF: begin
				ncol = (sum_c > (VAL_W+1)'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(sum_c);
			end
			CMD_CUB: begin
				ncol = (cnt0 > VAL_W'(col_q)) ? '0 : COL_W'(VAL_W'(col_q) - cnt0);
			end
			CMD_CUP: begin
				nrow = (a0 > VAL_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(a0);
				ncol = (a1 > VAL_W'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(a1);
			end
			CMD_ED: begin
				if (!head.params[0].dflt && (head.params[0].val == ED_ALL)) begin
					nrow = '0;
					ncol = '0;
				end
			end
			CMD_SGR: begin
				// Walk one parameter a cycle; an empty list resets the attribute
				if (head.pcount == '0) begin
					nattr = ATTR_RESET;
				end else begin
					step_last = (PCNT_W'(idx_q) + PCNT_W'(1) == head.pcount);
					if (pv == SGR_RESET) begin
						nattr = ATTR_RESET;
					end else if (pv == SGR_BOLD) begin
						nattr = attr_q | ATTR_BRIGHT;
					end else if ((pv >= SGR_FG_LO) && (pv <= SGR_FG_HI)) begin
						nattr = {attr_q[7:3], sub30[2:0]};
					end else if ((pv >= SGR_BG_LO) && (pv <= SGR_BG_HI)) begin
						nattr = {1'b0, sub40[2:0], attr_q[3:0]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Cursor, attribute and parameter walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			attr_q <= ATTR_RESET;
			idx_q  <= '0;
		end else if (advance) begin
			row_q  <= nrow;
			col_q  <= ncol;
			attr_q <= nattr;
			idx_q  <= pop ? '0 : idx_q + PIDX_W'(1);
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= '{row: nrow, col: ncol, attribute: nattr, parser_mode: head.mode};
		end
	end

endmodule

`default_nettype wire
